// ===== rtl/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// shared types and constants of the breadth-first path search block
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

  localparam int unsigned VtxW  = 5;
  localparam int unsigned KindW = 2;

  typedef logic [VtxW-1:0] vtx_t;

  typedef enum logic [KindW-1:0] {
    KIND_ADD_VERTEX = 2'd0,
    KIND_ADD_EDGE   = 2'd1,
    KIND_SET_LOCK   = 2'd2,
    KIND_SEARCH     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    EMIT_END   = 2'd0,
    EMIT_WALK  = 2'd1,
    EMIT_START = 2'd2
  } emit_sel_e;

  // controller to datapath
  typedef struct packed {
    logic      add_vertex;
    logic      set_lock;
    logic      deg_latch_a;
    logic      edge_wr_a;
    logic      edge_wr_b;
    logic      bfs_init;
    logic      q_read;
    logic      cur_load;
    logic      adj_read;
    logic      adj_visit;
    logic      set_found;
    logic      clr_found;
    logic      walk_load;
    logic      walk_step;
    logic      emit;
    emit_sel_e emit_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  a_ok;
    logic  b_ok;
    logic  same_ab;
    logic  edge_ok;
    logic  q_empty;
    logic  cur_is_end;
    logic  adj_done;
    logic  walk_at_start;
    logic  out_free;
    logic  found;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/bps_in_if.sv =====
// ----------------------------------------------------------------------------
// bps_in_if
// command channel: valid/ready handshake with one command word
// ----------------------------------------------------------------------------
`default_nettype none

interface bps_in_if;
  logic                            valid;
  logic                            ready;
  logic [bps_pkg::KindW-1:0]       kind;
  bps_pkg::vtx_t                   vertex_a;
  bps_pkg::vtx_t                   vertex_b;
  logic                            lock_value;

  modport source (output valid, kind, vertex_a, vertex_b, lock_value, input ready);
  modport sink   (input valid, kind, vertex_a, vertex_b, lock_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/bps_out_if.sv =====
// ----------------------------------------------------------------------------
// bps_out_if
// path channel: valid/ready handshake with one path word
// ----------------------------------------------------------------------------
`default_nettype none

interface bps_out_if;
  logic          valid;
  logic          ready;
  bps_pkg::vtx_t path_vertex;
  logic          found;
  logic          last;

  modport source (output valid, path_vertex, found, last, input ready);
  modport sink   (input valid, path_vertex, found, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/bps_datapath.sv =====
// ----------------------------------------------------------------------------
// bps_datapath
// graph storage, search queue, marks and the output word register
// ----------------------------------------------------------------------------
`default_nettype none

module bps_datapath #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned MAX_DEGREE   = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          take_i,
  input  wire logic [bps_pkg::KindW-1:0]     kind_i,
  input  wire bps_pkg::vtx_t                 vertex_a_i,
  input  wire bps_pkg::vtx_t                 vertex_b_i,
  input  wire logic                          lock_value_i,
  input  wire bps_pkg::cmd_t                 cmd_i,
  output bps_pkg::sts_t                      sts_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output bps_pkg::vtx_t                      out_vertex_o,
  output logic                               out_found_o,
  output logic                               out_last_o
);
  import bps_pkg::*;

  localparam int unsigned VIW      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW       = $clog2(MAX_VERTICES + 1);
  localparam int unsigned DW       = $clog2(MAX_DEGREE + 1);
  localparam int unsigned AdjDepth = MAX_VERTICES * MAX_DEGREE;
  localparam int unsigned AW       = (AdjDepth > 1) ? $clog2(AdjDepth) : 1;

  // latched command word
  kind_e  kind_q;
  vtx_t   a_q, b_q;
  logic   lv_q;

  logic [CW-1:0]           cnt_q;
  logic [DW-1:0]           degree_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] locked_q, visited_q;
  vtx_t                    parent_q [MAX_VERTICES];
  vtx_t                    adj_mem  [AdjDepth];
  vtx_t                    q_mem    [MAX_VERTICES];
  vtx_t                    adj_rdata_q, q_rdata_q;
  logic [CW-1:0]           head_q, tail_q;
  vtx_t                    cur_q, walk_q;
  logic [DW-1:0]           dcur_q, j_q, deg_a_q;
  logic                    found_q;
  logic                    out_valid_q, out_found_q, out_last_q;
  vtx_t                    out_vertex_q;

  function automatic logic [AW-1:0] adj_addr(input vtx_t idx, input logic [DW-1:0] d);
    adj_addr = AW'(AW'(idx) * AW'(MAX_DEGREE)) + AW'(d);
  endfunction

  // degree read port
  logic [VIW-1:0] deg_idx;
  logic [DW-1:0]  deg_rd;
  always_comb begin
    if (cmd_i.cur_load) begin
      deg_idx = VIW'(q_rdata_q);
    end else if (cmd_i.deg_latch_a) begin
      deg_idx = VIW'(a_q);
    end else begin
      deg_idx = VIW'(b_q);
    end
  end
  assign deg_rd = degree_q[deg_idx];

  // neighbor test
  logic [VIW-1:0] nb_idx;
  logic           nb_take;
  assign nb_idx  = VIW'(adj_rdata_q);
  assign nb_take = !visited_q[nb_idx] && !locked_q[nb_idx];

  // parent read port
  vtx_t parent_rd;
  assign parent_rd = parent_q[cmd_i.walk_load ? VIW'(b_q) : VIW'(walk_q)];

  logic a_ok, b_ok, same_ab, edge_ok, out_free;
  assign a_ok    = 8'(a_q) < 8'(cnt_q);
  assign b_ok    = 8'(b_q) < 8'(cnt_q);
  assign same_ab = a_q == b_q;
  assign out_free = !out_valid_q || out_ready_i;
  always_comb begin
    if (same_ab) begin
      edge_ok = a_ok && (7'(deg_a_q) + 7'd2 <= 7'(MAX_DEGREE));
    end else begin
      edge_ok = a_ok && b_ok && (7'(deg_a_q) < 7'(MAX_DEGREE)) &&
                (7'(deg_rd) < 7'(MAX_DEGREE));
    end
  end

  always_comb begin
    sts_o.kind          = kind_q;
    sts_o.a_ok          = a_ok;
    sts_o.b_ok          = b_ok;
    sts_o.same_ab       = same_ab;
    sts_o.edge_ok       = edge_ok;
    sts_o.q_empty       = head_q == tail_q;
    sts_o.cur_is_end    = q_rdata_q == b_q;
    sts_o.adj_done      = j_q == dcur_q;
    sts_o.walk_at_start = walk_q == a_q;
    sts_o.out_free      = out_free;
    sts_o.found         = found_q;
  end

  // command word latch
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      kind_q <= kind_e'(kind_i);
      a_q    <= vertex_a_i;
      b_q    <= vertex_b_i;
      lv_q   <= lock_value_i;
    end
  end

  // control state: counts, degrees, locks, marks, pointers, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      locked_q    <= '0;
      visited_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        degree_q[i] <= '0;
      end
    end else begin
      if (cmd_i.add_vertex && (cnt_q != CW'(MAX_VERTICES))) begin
        degree_q[VIW'(cnt_q)] <= '0;
        locked_q[VIW'(cnt_q)] <= 1'b0;
        cnt_q                 <= cnt_q + 1'b1;
      end
      if (cmd_i.set_lock && (8'(a_q) < 8'(MAX_VERTICES))) begin
        locked_q[VIW'(a_q)] <= lv_q;
      end
      if (cmd_i.edge_wr_a) begin
        degree_q[VIW'(a_q)] <= deg_a_q + 1'b1;
      end
      if (cmd_i.edge_wr_b) begin
        degree_q[VIW'(b_q)] <= deg_rd + 1'b1;
      end
      if (cmd_i.bfs_init) begin
        visited_q            <= '0;
        visited_q[VIW'(a_q)] <= 1'b1;
        head_q               <= '0;
        tail_q               <= CW'(1);
      end
      if (cmd_i.q_read) begin
        head_q <= head_q + 1'b1;
      end
      if (cmd_i.adj_visit && nb_take) begin
        visited_q[nb_idx] <= 1'b1;
        if (tail_q != CW'(MAX_VERTICES)) begin
          tail_q <= tail_q + 1'b1;
        end
      end
      if (cmd_i.set_found) begin
        found_q <= 1'b1;
      end else if (cmd_i.clr_found) begin
        found_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // adjacency memory: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_wr_a) begin
      adj_mem[adj_addr(a_q, deg_a_q)] <= b_q;
    end else if (cmd_i.edge_wr_b) begin
      adj_mem[adj_addr(b_q, deg_rd)] <= a_q;
    end
    if (cmd_i.adj_read) begin
      adj_rdata_q <= adj_mem[adj_addr(cur_q, j_q)];
    end
  end

  // search queue memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.bfs_init) begin
      q_mem[0] <= a_q;
    end else if (cmd_i.adj_visit && nb_take && (tail_q != CW'(MAX_VERTICES))) begin
      q_mem[VIW'(tail_q)] <= adj_rdata_q;
    end
    if (cmd_i.q_read) begin
      q_rdata_q <= q_mem[VIW'(head_q)];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.deg_latch_a) begin
      deg_a_q <= deg_rd;
    end
    if (cmd_i.cur_load) begin
      cur_q  <= q_rdata_q;
      dcur_q <= deg_rd;
      j_q    <= '0;
    end else if (cmd_i.adj_read) begin
      j_q <= j_q + 1'b1;
    end
    if (cmd_i.adj_visit && nb_take) begin
      parent_q[nb_idx] <= cur_q;
    end
    if (cmd_i.walk_load || cmd_i.walk_step) begin
      walk_q <= parent_rd;
    end
    if (cmd_i.emit) begin
      case (cmd_i.emit_sel)
        EMIT_END: begin
          out_vertex_q <= b_q;
          out_found_q  <= found_q;
          out_last_q   <= 1'b0;
        end
        EMIT_WALK: begin
          out_vertex_q <= walk_q;
          out_found_q  <= 1'b1;
          out_last_q   <= 1'b0;
        end
        default: begin
          out_vertex_q <= a_q;
          out_found_q  <= found_q;
          out_last_q   <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_vertex_o = out_vertex_q;
  assign out_found_o  = out_found_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/bps_controller.sv =====
// ----------------------------------------------------------------------------
// bps_controller
// sequencer for graph updates, the breadth-first walk and path emission
// ----------------------------------------------------------------------------
`default_nettype none

module bps_controller (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bps_pkg::sts_t sts_i,
  output bps_pkg::cmd_t      cmd_o
);
  import bps_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_DISPATCH = 12'b000000000010,
    S_EDGE_B   = 12'b000000000100,
    S_EDGE_WA  = 12'b000000001000,
    S_EDGE_WB  = 12'b000000010000,
    S_POP      = 12'b000000100000,
    S_CUR      = 12'b000001000000,
    S_ADJ_RD   = 12'b000010000000,
    S_ADJ_CHK  = 12'b000100000000,
    S_EM_END   = 12'b001000000000,
    S_WALK     = 12'b010000000000,
    S_EM_START = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.kind)
          KIND_ADD_VERTEX: begin
            cmd_o.add_vertex = 1'b1;
            state_d          = S_IDLE;
          end
          KIND_SET_LOCK: begin
            cmd_o.set_lock = 1'b1;
            state_d        = S_IDLE;
          end
          KIND_ADD_EDGE: begin
            cmd_o.deg_latch_a = 1'b1;
            state_d           = S_EDGE_B;
          end
          default: begin
            if (!(sts_i.a_ok && sts_i.b_ok)) begin
              cmd_o.clr_found = 1'b1;
              state_d         = S_EM_END;
            end else if (sts_i.same_ab) begin
              cmd_o.set_found = 1'b1;
              state_d         = S_EM_END;
            end else begin
              cmd_o.bfs_init = 1'b1;
              state_d        = S_POP;
            end
          end
        endcase
      end
      S_EDGE_B: begin
        state_d = sts_i.edge_ok ? S_EDGE_WA : S_IDLE;
      end
      S_EDGE_WA: begin
        cmd_o.edge_wr_a = 1'b1;
        state_d         = S_EDGE_WB;
      end
      S_EDGE_WB: begin
        cmd_o.edge_wr_b = 1'b1;
        state_d         = S_IDLE;
      end
      S_POP: begin
        if (sts_i.q_empty) begin
          cmd_o.clr_found = 1'b1;
          state_d         = S_EM_END;
        end else begin
          cmd_o.q_read = 1'b1;
          state_d      = S_CUR;
        end
      end
      S_CUR: begin
        if (sts_i.cur_is_end) begin
          cmd_o.set_found = 1'b1;
          state_d         = S_EM_END;
        end else begin
          cmd_o.cur_load = 1'b1;
          state_d        = S_ADJ_RD;
        end
      end
      S_ADJ_RD: begin
        if (sts_i.adj_done) begin
          state_d = S_POP;
        end else begin
          cmd_o.adj_read = 1'b1;
          state_d        = S_ADJ_CHK;
        end
      end
      S_ADJ_CHK: begin
        cmd_o.adj_visit = 1'b1;
        state_d         = S_ADJ_RD;
      end
      S_EM_END: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_END;
          if (sts_i.found && !sts_i.same_ab) begin
            cmd_o.walk_load = 1'b1;
            state_d         = S_WALK;
          end else begin
            state_d = S_EM_START;
          end
        end
      end
      S_WALK: begin
        if (sts_i.walk_at_start) begin
          state_d = S_EM_START;
        end else if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_WALK;
          cmd_o.walk_step = 1'b1;
        end
      end
      S_EM_START: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_START;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bfs_path_search_core.sv =====
// ----------------------------------------------------------------------------
// bfs_path_search_core
// breadth-first shortest path search over a small undirected graph
// ----------------------------------------------------------------------------
// Takes one command word at a time: add vertex, add edge, set lock or search.
// Add vertex and set lock end in the dispatch state, add edge goes on through
// a degree check and two memory writes. A search seeds the queue, pops and
// loads each vertex, reads and checks each adjacency entry, then loads the path
// words as the output register frees up; the walk is bound by the single-port
// adjacency and queue memories, both read through a register. The block takes a
// new command as soon as the last path word sits in the output register. Visited
// marks are cleared at the start of each search walk; no clearing pass follows reset.
`default_nettype none

module bfs_path_search_core #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned MAX_DEGREE   = 8
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  bps_in_if.sink    in_i,
  bps_out_if.source out_o
);
  import bps_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic take;

  // a command word is taken when the sequencer is idle
  assign in_i.ready = in_ready;
  assign take       = in_i.valid && in_ready;

  // sequencer: walks each command through its steps
  bps_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage, queue, marks and the output word register
  bps_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .kind_i       (in_i.kind),
    .vertex_a_i   (in_i.vertex_a),
    .vertex_b_i   (in_i.vertex_b),
    .lock_value_i (in_i.lock_value),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_vertex_o (out_o.path_vertex),
    .out_found_o  (out_o.found),
    .out_last_o   (out_o.last)
  );

`ifndef SYNTHESIS
  // a path word is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("path word loaded over a pending word");

  // the queue is never read past its tail
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.q_read |-> !sts.q_empty)
    else $error("queue read while empty");

  // the two halves of an edge are written in back-to-back cycles
  a_edge_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.edge_wr_a |=> cmd.edge_wr_b)
    else $error("edge written in one direction only");
`endif

endmodule

`default_nettype wire

// ===== sim/bps_test_if.sv =====
// ----------------------------------------------------------------------------
// bps_test_if
// note: the channel interfaces come from the rtl; this file holds bps_test_pkg and nothing else
// ----------------------------------------------------------------------------
`default_nettype none

package bps_test_pkg;
  localparam int unsigned NumVertices = 32;
  localparam int unsigned NumDegree   = 8;
endpackage

`default_nettype wire

// ===== sim/bfs_path_search_core_test.sv =====
// ----------------------------------------------------------------------------
// bfs_path_search_core_test
// self-checking bench for the breadth-first path search block
// ----------------------------------------------------------------------------
// Builds small graphs, sets and clears locks and runs searches through the
// command channel. A behavioral copy of the graph predicts every path word.
// The output monitor compares each word with the oldest expected one. Both
// channels see random idle bursts except in the final stretch of the run.
`default_nettype none

module bfs_path_search_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bps_pkg::*;
  import bps_test_pkg::*;

  typedef struct packed {
    kind_e kind;
    vtx_t  va;
    vtx_t  vb;
    logic  lv;
  } cmd_word_t;

  typedef struct packed {
    vtx_t pv;
    logic fnd;
    logic lst;
  } path_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bps_in_if  cmd_ch ();
  bps_out_if path_ch ();

  bfs_path_search_core #(
    .MAX_VERTICES(NumVertices),
    .MAX_DEGREE  (NumDegree)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch),
    .out_o (path_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // graph shadow used for prediction
  int unsigned n_vtx;
  int unsigned deg_q [NumVertices];
  vtx_t        adj_q [NumVertices][NumDegree];
  bit          lock_q [NumVertices];

  cmd_word_t  pending_cmds [$];
  path_word_t expected_path [$];
  int unsigned errors = 0;
  int unsigned accepted = 0;
  bit          quiet = 0;       // no idling in the final stretch
  bit          hold_off = 0;    // sender waits for all path words
  longint      cycles = 0;

  // append to the tail of the expected and pending queues
  function automatic void add_word(path_word_t w);
    expected_path.insert(expected_path.size(), w);
  endfunction

  function automatic void add_cmd(cmd_word_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // predict the effect of one command on the graph and the path words
  task automatic apply_cmd(input cmd_word_t c);
    bit   seen [NumVertices];
    int   par  [NumVertices];
    vtx_t bq   [$];
    int   cur, k;
    bit   hit;
    int unsigned s, e;
    s = c.va;
    e = c.vb;
    case (c.kind)
      KIND_ADD_VERTEX: begin
        if (n_vtx < NumVertices) begin
          deg_q[n_vtx] = 0;
          lock_q[n_vtx] = 0;
          n_vtx++;
        end
      end
      KIND_ADD_EDGE: begin
        if (s < n_vtx && e < n_vtx) begin
          if ((s == e) ? (deg_q[s] + 2 <= NumDegree)
                       : (deg_q[s] < NumDegree && deg_q[e] < NumDegree)) begin
            adj_q[s][deg_q[s]] = e;
            deg_q[s]++;
            adj_q[e][deg_q[e]] = s;
            deg_q[e]++;
          end
        end
      end
      KIND_SET_LOCK: lock_q[s] = c.lv;
      default: begin
        if (s >= n_vtx || e >= n_vtx) begin
          add_word({vtx_t'(e), 1'b0, 1'b0});
          add_word({vtx_t'(s), 1'b0, 1'b1});
        end else if (s == e) begin
          add_word({vtx_t'(e), 1'b1, 1'b0});
          add_word({vtx_t'(s), 1'b1, 1'b1});
        end else begin
          foreach (seen[i]) begin
            seen[i] = 0;
            par[i] = -1;
          end
          hit = 0;
          seen[s] = 1;
          bq.insert(bq.size(), vtx_t'(s));
          while (bq.size() > 0 && !hit) begin
            cur = bq.pop_front();
            if (cur == e) hit = 1;
            else begin
              for (int j = 0; j < deg_q[cur]; j++) begin
                if (!seen[adj_q[cur][j]] && !lock_q[adj_q[cur][j]]) begin
                  seen[adj_q[cur][j]] = 1;
                  par[adj_q[cur][j]] = cur;
                  bq.insert(bq.size(), adj_q[cur][j]);
                end
              end
            end
          end
          add_word({vtx_t'(e), hit, 1'b0});
          if (hit) begin
            cur = par[e];
            k = 1;
            while (cur != s && cur >= 0 && k < 31) begin
              add_word({vtx_t'(cur), 1'b1, 1'b0});
              cur = par[cur];
              k++;
            end
          end
          add_word({vtx_t'(s), hit, 1'b1});
        end
      end
    endcase
  endtask

  // command driver: idle bursts and the hold-off pause
  int unsigned src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_word_t nxt;
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
      {cmd_ch.kind, cmd_ch.vertex_a, cmd_ch.vertex_b, cmd_ch.lock_value} <= '0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        nxt = {kind_e'(cmd_ch.kind), cmd_ch.vertex_a, cmd_ch.vertex_b, cmd_ch.lock_value};
        apply_cmd(nxt);
        void'(pending_cmds.pop_front());
        accepted++;
        if (!quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 6);
      end
      if (!(cmd_ch.valid && !cmd_ch.ready)) begin
        if (src_gap > 0) begin
          src_gap--;
          cmd_ch.valid <= 1'b0;
        end else if (pending_cmds.size() > 0 && !(hold_off && expected_path.size() > 0)) begin
          nxt = pending_cmds[0];
          cmd_ch.valid <= 1'b1;
          cmd_ch.kind <= nxt.kind;
          cmd_ch.vertex_a <= nxt.va;
          cmd_ch.vertex_b <= nxt.vb;
          cmd_ch.lock_value <= nxt.lv;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // path monitor with random back-pressure
  int unsigned snk_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    path_word_t got, want;
    if (!rst_ni) begin
      path_ch.ready <= 1'b0;
    end else begin
      if (path_ch.valid && path_ch.ready) begin
        got = {path_ch.path_vertex, path_ch.found, path_ch.last};
        if (expected_path.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected path word %p", got);
        end else begin
          want = expected_path.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"path word mismatch: expected vtx %0d found %0b last %0b, ",
                        "got vtx %0d found %0b last %0b"},
                       want.pv, want.fnd, want.lst, got.pv, got.fnd, got.lst);
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        path_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        snk_gap = $urandom_range(0, 5);
        path_ch.ready <= 1'b0;
      end else begin
        path_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic cmd_word_t mk(kind_e k, int unsigned a, int unsigned b, bit l);
    return {k, vtx_t'(a), vtx_t'(b), l};
  endfunction

  // random vertices, edges (some to missing vertices), locks and searches
  task automatic add_random_block(int unsigned n_new, int unsigned n_edges, int unsigned n_srch);
    int unsigned hi;
    repeat (n_new) add_cmd(mk(KIND_ADD_VERTEX, 0, 0, 0));
    hi = 31;
    repeat (n_edges) add_cmd(mk(KIND_ADD_EDGE,
      $urandom_range(0, hi), $urandom_range(0, hi), 0));
    repeat (3) add_cmd(mk(KIND_SET_LOCK, $urandom_range(0, 31), 0,
      $urandom_range(0, 3) == 0));
    repeat (n_srch) add_cmd(mk(KIND_SEARCH, $urandom_range(0, 31),
      $urandom_range(0, 31), 0));
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || cmd_ch.valid) @(posedge clk_i);
  endtask

  initial begin
    n_vtx = 0;
    foreach (deg_q[i]) begin
      deg_q[i] = 0;
      lock_q[i] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty graph, self search, chain, locks, self loop, full list
    add_cmd(mk(KIND_SEARCH, 0, 31, 0));
    add_cmd(mk(KIND_ADD_EDGE, 0, 1, 0));
    repeat (4) add_cmd(mk(KIND_ADD_VERTEX, 0, 0, 0));
    add_cmd(mk(KIND_SEARCH, 2, 2, 0));
    add_cmd(mk(KIND_ADD_EDGE, 0, 1, 0));
    add_cmd(mk(KIND_ADD_EDGE, 1, 2, 0));
    add_cmd(mk(KIND_ADD_EDGE, 2, 3, 0));
    add_cmd(mk(KIND_SEARCH, 0, 3, 0));
    add_cmd(mk(KIND_SET_LOCK, 2, 0, 1));
    add_cmd(mk(KIND_SEARCH, 0, 3, 0));
    add_cmd(mk(KIND_SEARCH, 2, 0, 0));
    add_cmd(mk(KIND_SEARCH, 0, 2, 0));
    add_cmd(mk(KIND_SET_LOCK, 31, 0, 1));
    add_cmd(mk(KIND_SET_LOCK, 2, 0, 0));
    repeat (4) add_cmd(mk(KIND_ADD_EDGE, 3, 3, 0));
    add_cmd(mk(KIND_ADD_EDGE, 3, 0, 0));
    add_cmd(mk(KIND_SEARCH, 3, 0, 0));
    add_cmd(mk(KIND_SEARCH, 31, 0, 0));
    wait_drained();

    // sender waits for every path word before going on
    hold_off = 1;
    add_random_block(4, 6, 3);
    wait_drained();
    hold_off = 0;

    // random: grow to full table, then keep editing and searching
    for (int r = 0; r < 12; r++) add_random_block(2, 12, 12);
    quiet = 1;
    add_random_block(2, 10, 12);
    wait_drained();

    while (expected_path.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/bps_pkg.sv
rtl/bps_in_if.sv
rtl/bps_out_if.sv
rtl/bps_datapath.sv
rtl/bps_controller.sv
rtl/bfs_path_search_core.sv
sim/bps_test_if.sv
sim/bfs_path_search_core_test.sv
